// ----- sv/assert_macros.svh -----
// Assertion macros used by the translator's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/sgit_pkg.sv -----
// Types and constants of the scatter-gather index translator.
package sgit_pkg;

  localparam int OFF_W  = 64;
  localparam int SIZE_W = 32;
  localparam int POS_W  = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_EMIT
  } state_t;

  // search request seen by every cell while a scan runs
  typedef struct packed {
    logic              is_lookup;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] lookup_index;
  } query_t;

  // list update broadcast to the cells
  typedef struct packed {
    logic              append;
    logic              compact;
    logic [POS_W-1:0]  sel;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] start;
  } cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [POS_W-1:0]  pos;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] start;
  } token_t;

endpackage

// ----- sv/sgit_cell.sv -----
// One list entry of the translator with its stage of the search chain.
module sgit_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sgit_pkg::query_t              query,
  input  sgit_pkg::cmd_t                cmd,
  input  logic [CNT_W-1:0]              held_count,
  input  sgit_pkg::token_t              tok_in,
  output sgit_pkg::token_t              tok_out,
  input  logic [sgit_pkg::OFF_W-1:0]    nbr_offset,
  input  logic [sgit_pkg::SIZE_W-1:0]   nbr_size,
  input  logic [sgit_pkg::SIZE_W-1:0]   nbr_start,
  output logic [sgit_pkg::OFF_W-1:0]    cell_offset,
  output logic [sgit_pkg::SIZE_W-1:0]   cell_size,
  output logic [sgit_pkg::SIZE_W-1:0]   cell_start
);
  import sgit_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
  localparam logic [POS_W-1:0] IDX_P = POS_W'(INDEX);

  logic [SIZE_W-1:0] rel;
  logic              held;
  logic              rm_match;
  logic              lk_match;
  logic              hit_here;
  token_t            tok_next;

  // match this entry against the request
  always_comb begin
    rel      = query.lookup_index - cell_start;
    held     = IDX_C < held_count;
    rm_match = (cell_offset == query.offset) && (cell_size == query.size);
    lk_match = (query.lookup_index >= cell_start) && (rel < cell_size);
    hit_here = tok_in.active && !tok_in.hit && held &&
               (query.is_lookup ? lk_match : rm_match);
    tok_next = tok_in;
    if (hit_here) begin
      tok_next.hit    = 1'b1;
      tok_next.pos    = IDX_P;
      tok_next.offset = cell_offset;
      tok_next.size   = cell_size;
      tok_next.start  = cell_start;
    end
  end

  // advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
      tok_out.hit    <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // load an appended block, or pull the right neighbor on a remove
  always_ff @(posedge clk) begin
    if (cmd.append && (cmd.sel == IDX_P)) begin
      cell_offset <= cmd.offset;
      cell_size   <= cmd.size;
      cell_start  <= cmd.start;
    end else if (cmd.compact && (IDX_P >= cmd.sel)) begin
      cell_offset <= nbr_offset;
      cell_size   <= nbr_size;
      cell_start  <= nbr_start - cmd.size;
    end
  end

endmodule

// ----- sv/scatter_gather_index_translate.sv -----
// Top level of the scatter-gather index translator: control, counters and the cell chain.
//
// Holds an ordered list of up to MAX_BLOCKS memory blocks (offset, size) that form
// one logical byte area. Each input beat (op, block_offset, block_size, lookup_index)
// on the in_valid/in_ready channel yields exactly one result beat on out_valid/
// out_ready: append, remove first match, look up a byte index, or clear.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes base_address, which is
// added to every looked-up address; write it only while the block is idle.
// Append, clear and a lookup on an empty list go straight to S_EMIT, which loads the
// output register. Remove and lookup latch the request, launch a search token from the
// launch register, pass it down the chain of cells one cell per cycle, then finish the
// address in S_FIN before S_EMIT loads the result.
// The next beat is accepted once the block is back idle after the result is loaded,
// so no beat is taken while one is in flight and the chain length sets the rate of
// remove and lookup.
// The result sits in an output register; while the receiver stalls the finished
// result holds, the block still takes one more beat and waits before delivering it.
// Synchronous reset empties the list, sets base_address to 1 and drops any result.
module scatter_gather_index_translate #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] block_offset,
  input  logic [31:0] block_size,
  input  logic [31:0] lookup_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        found,
  output logic [3:0]  entry_index,
  output logic [63:0] block_offset_out,
  output logic [31:0] block_size_out,
  output logic [63:0] byte_address,
  output logic [31:0] total_bytes,
  output logic [4:0]  block_count,
  output logic        is_empty
);
  import sgit_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(MAX_BLOCKS);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  held_count;
  logic [SIZE_W-1:0] held_total;
  logic [OFF_W-1:0]  base_address;

  query_t            query;
  op_t               q_op;
  cmd_t              cmd;
  logic              launch;
  token_t            tok_head;
  token_t            tok [0:MAX_BLOCKS];
  logic [OFF_W-1:0]  c_off   [0:MAX_BLOCKS-1];
  logic [SIZE_W-1:0] c_size  [0:MAX_BLOCKS-1];
  logic [SIZE_W-1:0] c_start [0:MAX_BLOCKS-1];

  logic              accept;
  logic              full;
  logic [SIZE_W:0]   sum_total;
  logic              overflow;
  logic              out_load;
  token_t            tok_last;

  // result staging
  logic [2:0]        r_status;
  logic              r_found;
  logic [POS_W-1:0]  r_pos;
  logic [OFF_W-1:0]  r_off;
  logic [SIZE_W-1:0] r_size;
  logic [OFF_W-1:0]  r_part;
  logic [OFF_W-1:0]  r_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (held_count == FULL_C);
  assign sum_total = {1'b0, held_total} + {1'b0, block_size};
  assign overflow  = sum_total[SIZE_W];
  assign tok_last  = tok[MAX_BLOCKS];

  // start the token once the request sits in the query register
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept && ((op_t'(op) == OP_REMOVE) ||
                           ((op_t'(op) == OP_LOOKUP) && (held_count != '0)));
    end
  end

  always_comb begin
    tok_head        = '0;
    tok_head.active = launch;
  end

  assign tok[0] = tok_head;

  // next state and list commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    out_load      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_APPEND: begin
              cmd.append = !full && !overflow;
              cmd.sel    = POS_W'(held_count);
              cmd.offset = block_offset;
              cmd.size   = block_size;
              cmd.start  = held_total;
              state_next = S_EMIT;
            end
            OP_REMOVE: begin
              state_next = S_SCAN;
            end
            OP_LOOKUP: begin
              if (held_count == '0) begin
                state_next = S_EMIT;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok_last.active) begin
          if (tok_last.hit && !query.is_lookup) begin
            cmd.compact = 1'b1;
            cmd.sel     = tok_last.pos;
            cmd.size    = query.size;
          end
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // base address register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= 64'd1;
    end else if (cfg_valid && cfg_ready) begin
      base_address <= cfg_data;
    end
  end

  // list count and total
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      held_total <= '0;
    end else if (cmd.append) begin
      held_count <= CNT_W'(held_count + 1'b1);
      held_total <= sum_total[SIZE_W-1:0];
    end else if (cmd.compact) begin
      held_count <= CNT_W'(held_count - 1'b1);
      held_total <= held_total - query.size;
    end else if (accept && (op_t'(op) == OP_CLEAR)) begin
      held_count <= '0;
      held_total <= '0;
    end
  end

  // latch the request and build the result
  always_ff @(posedge clk) begin
    if (accept) begin
      q_op               <= op_t'(op);
      query.is_lookup    <= (op_t'(op) == OP_LOOKUP);
      query.offset       <= block_offset;
      query.size         <= block_size;
      query.lookup_index <= lookup_index;
      r_found            <= 1'b0;
      r_pos              <= '0;
      r_off              <= '0;
      r_size             <= '0;
      r_addr             <= '0;
      r_status           <= ST_OK;
      case (op_t'(op))
        OP_APPEND: begin
          if (full) begin
            r_status <= ST_FULL;
          end else if (overflow) begin
            r_status <= ST_OVERFLOW;
          end else begin
            r_pos <= POS_W'(held_count);
          end
        end
        OP_LOOKUP: begin
          if (held_count == '0) begin
            r_status <= ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_SCAN && tok_last.active && tok_last.hit) begin
      r_found <= 1'b1;
      r_pos   <= tok_last.pos;
      if (q_op == OP_LOOKUP) begin
        r_off  <= tok_last.offset;
        r_size <= tok_last.size;
        r_part <= tok_last.offset +
                  {{(OFF_W-SIZE_W){1'b0}}, query.lookup_index - tok_last.start};
      end
    end else if (state == S_FIN && r_found && q_op == OP_LOOKUP) begin
      r_addr <= base_address + r_part;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status           <= r_status;
      found            <= r_found;
      entry_index      <= 4'(r_pos);
      block_offset_out <= r_off;
      block_size_out   <= r_size;
      byte_address     <= r_addr;
      total_bytes      <= held_total;
      block_count      <= 5'(held_count);
      is_empty         <= (held_count == '0) || (held_total == '0);
    end
  end

  // chain of cells
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    logic [OFF_W-1:0]  nbr_off;
    logic [SIZE_W-1:0] nbr_size;
    logic [SIZE_W-1:0] nbr_start;
    if (i < MAX_BLOCKS - 1) begin : g_mid
      assign nbr_off   = c_off[i+1];
      assign nbr_size  = c_size[i+1];
      assign nbr_start = c_start[i+1];
    end else begin : g_end
      assign nbr_off   = c_off[i];
      assign nbr_size  = c_size[i];
      assign nbr_start = c_start[i];
    end
    sgit_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .query       (query),
      .cmd         (cmd),
      .held_count  (held_count),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1]),
      .nbr_offset  (nbr_off),
      .nbr_size    (nbr_size),
      .nbr_start   (nbr_start),
      .cell_offset (c_off[i]),
      .cell_size   (c_size[i]),
      .cell_start  (c_start[i])
    );
  end

  // checks
  `ASSERT_HOLDS(a_count_range, clk, rst, held_count <= FULL_C)
  `ASSERT_IMPLIES(a_empty_total, clk, rst, held_count == '0, held_total == '0)
  `ASSERT_IMPLIES(a_token_in_scan, clk, rst, tok_last.active, state == S_SCAN)
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, state != S_IDLE)

endmodule

// ----- bench/sgit_checker.sv -----
// Checker for the scatter-gather index translator: predicts every result beat and compares it.
module sgit_checker #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] block_offset,
  input  logic [31:0] block_size,
  input  logic [31:0] lookup_index,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic        found,
  input  logic [3:0]  entry_index,
  input  logic [63:0] block_offset_out,
  input  logic [31:0] block_size_out,
  input  logic [63:0] byte_address,
  input  logic [31:0] total_bytes,
  input  logic [4:0]  block_count,
  input  logic        is_empty,
  output int          errors,
  output int          outstanding
);
  import sgit_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic        found;
    logic [3:0]  entry_index;
    logic [63:0] blk_off;
    logic [31:0] blk_size;
    logic [63:0] addr;
    logic [31:0] total;
    logic [4:0]  count;
    logic        is_empty;
  } xlate_result_t;

  // shadow of the block list and the base register
  logic [63:0]   base_q;
  logic [63:0]   list_off   [MAX_BLOCKS];
  logic [31:0]   list_size  [MAX_BLOCKS];
  logic [31:0]   list_start [MAX_BLOCKS];
  int            list_len;
  logic [31:0]   list_total;
  xlate_result_t expected_q [$];
  int            mismatch_count = 0;
  int            pending_count = 0;

  assign errors      = mismatch_count;
  assign outstanding = pending_count;

  // apply one op to the shadow list and return the result it yields
  function automatic xlate_result_t apply_op(op_t o, logic [63:0] off, logic [31:0] sz,
                                             logic [31:0] idx);
    xlate_result_t r;
    int            hit;
    logic [32:0]   sum;
    r   = '{default: '0};
    hit = list_len;
    case (o)
      OP_APPEND: begin
        sum = {1'b0, list_total} + {1'b0, sz};
        if (list_len >= MAX_BLOCKS) begin
          r.status = ST_FULL;
        end else if (sum[32]) begin
          r.status = ST_OVERFLOW;
        end else begin
          r.entry_index        = 4'(list_len);
          list_off[list_len]   = off;
          list_size[list_len]  = sz;
          list_start[list_len] = list_total;
          list_total           = sum[31:0];
          list_len++;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit == list_len && list_off[i] == off && list_size[i] == sz) hit = i;
        end
        if (hit < list_len) begin
          r.found       = 1'b1;
          r.entry_index = 4'(hit);
          // close the gap and pull later starts down by the removed size
          for (int j = hit; j + 1 < list_len; j++) begin
            list_off[j]   = list_off[j + 1];
            list_size[j]  = list_size[j + 1];
            list_start[j] = list_start[j + 1] - sz;
          end
          list_len--;
          list_total = list_total - sz;
        end
      end
      OP_LOOKUP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (hit == list_len && idx >= list_start[i] &&
                {1'b0, idx} < ({1'b0, list_start[i]} + {1'b0, list_size[i]})) hit = i;
          end
          if (hit < list_len) begin
            r.found       = 1'b1;
            r.entry_index = 4'(hit);
            r.blk_off     = list_off[hit];
            r.blk_size    = list_size[hit];
            r.addr        = base_q + list_off[hit] + {32'd0, idx - list_start[hit]};
          end
        end
      end
      default: begin
        list_len   = 0;
        list_total = '0;
      end
    endcase
    r.total    = list_total;
    r.count    = 5'(list_len);
    r.is_empty = (list_len == 0 || list_total == 0);
    return r;
  endfunction

  // print one mismatch line and count it
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic compare_result(xlate_result_t want);
    if (status !== want.status)
      report_mismatch("status", 64'(status), 64'(want.status));
    if (found !== want.found)
      report_mismatch("found", 64'(found), 64'(want.found));
    if (entry_index !== want.entry_index)
      report_mismatch("entry_index", 64'(entry_index), 64'(want.entry_index));
    if (block_offset_out !== want.blk_off)
      report_mismatch("block_offset_out", block_offset_out, want.blk_off);
    if (block_size_out !== want.blk_size)
      report_mismatch("block_size_out", 64'(block_size_out), 64'(want.blk_size));
    if (byte_address !== want.addr) report_mismatch("byte_address", byte_address, want.addr);
    if (total_bytes !== want.total)
      report_mismatch("total_bytes", 64'(total_bytes), 64'(want.total));
    if (block_count !== want.count)
      report_mismatch("block_count", 64'(block_count), 64'(want.count));
    if (is_empty !== want.is_empty)
      report_mismatch("is_empty", 64'(is_empty), 64'(want.is_empty));
  endtask

  // watch the three channels; check the result beat before queuing a new input beat
  always @(posedge clk) begin
    xlate_result_t want;
    if (rst) begin
      base_q     = 64'd1;
      list_len   = 0;
      list_total = '0;
      expected_q.delete();
      pending_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", {61'd0, status}, '0);
        end else begin
          want = expected_q.pop_front();
          compare_result(want);
        end
      end
      if (cfg_valid && cfg_ready) base_q = cfg_data;
      if (in_valid && in_ready)
        expected_q.push_back(apply_op(op_t'(op), block_offset, block_size, lookup_index));
      pending_count <= expected_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the scatter-gather index translator bench: clock, reset, stimulus and verdict.
module tb_top;
  import sgit_pkg::*;

  localparam int MAX_BLOCKS   = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 480;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [63:0] block_offset = '0;
  logic [31:0] block_size = '0;
  logic [31:0] lookup_index = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        found;
  logic [3:0]  entry_index;
  logic [63:0] block_offset_out;
  logic [31:0] block_size_out;
  logic [63:0] byte_address;
  logic [31:0] total_bytes;
  logic [4:0]  block_count;
  logic        is_empty;
  int          fail_count;
  int          outstanding;

  // pairs of {offset, size} appended lately, used to aim removes
  logic [95:0]     recent_q [$];
  longint unsigned approx_total = 0;
  int              sent_count = 0;
  int              idle_cycles = 0;

  scatter_gather_index_translate #(.MAX_BLOCKS(MAX_BLOCKS)) dut (.*);

  sgit_checker #(.MAX_BLOCKS(MAX_BLOCKS)) result_check (.*, .errors(fail_count));

  initial begin
    forever #4 clk = ~clk;
  end

  // end the run when no channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, bursts without it, and two long hold-offs
  initial begin : receiver
    int taken;
    int stall;
    taken = 0;
    forever begin
      stall = ((taken / 48) % 4 == 2) ? 0 : $urandom_range(0, 4);
      if (taken == 700 || taken == 1250) stall = stall + HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  function automatic logic [31:0] pick_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 8) return 32'd0;
    if (k < 70) return $urandom_range(1, 40);
    if (k < 88) return $urandom_range(41, 65535);
    if (k < 96) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  function automatic logic [63:0] pick_offset();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 10) return 64'd0;
    if (k < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  // offer one input beat after a random gap and hold it until taken
  task automatic send_beat(op_t o, logic [63:0] off, logic [31:0] sz, logic [31:0] idx);
    int gap;
    gap = ((sent_count / 64) % 4 == 3) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    block_offset <= off;
    block_size   <= sz;
    lookup_index <= idx;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // drop valid and wait until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_base(logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic append_random();
    logic [95:0] pair;
    if (recent_q.size() > 0 && $urandom_range(0, 9) == 0)
      pair = recent_q[$urandom_range(0, recent_q.size() - 1)];
    else
      pair = {pick_offset(), pick_size()};
    send_beat(OP_APPEND, pair[95:32], pair[31:0], $urandom);
    recent_q.push_back(pair);
    if (recent_q.size() > 32) void'(recent_q.pop_front());
    approx_total = approx_total + pair[31:0];
  endtask

  task automatic remove_random();
    logic [95:0] pair;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (recent_q.size() == 0 || k >= 85) begin
      pair = {pick_offset(), pick_size()};
    end else begin
      pair = recent_q[$urandom_range(0, recent_q.size() - 1)];
      // near miss: same offset, size off by one
      if (k >= 70) pair[31:0] = pair[31:0] + 32'd1;
    end
    send_beat(OP_REMOVE, pair[95:32], pair[31:0], $urandom);
  endtask

  task automatic lookup_random();
    int unsigned top_idx;
    top_idx = (approx_total > 64'hFFFF_FFF0) ? 32'hFFFF_FFFF : 32'(approx_total + 4);
    if ($urandom_range(0, 4) == 0)
      send_beat(OP_LOOKUP, {$urandom, $urandom}, $urandom, $urandom);
    else
      send_beat(OP_LOOKUP, {$urandom, $urandom}, $urandom, $urandom_range(0, top_idx));
  endtask

  task automatic clear_list();
    send_beat(OP_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
    approx_total = 0;
  endtask

  // episodes: clear, build a list, then mostly lookups and removes on it
  task automatic run_random(int count);
    int left;
    int n;
    int unsigned k;
    left = count;
    while (left > 0) begin
      clear_list();
      left--;
      n = $urandom_range(0, 18);
      repeat (n) begin
        append_random();
        left--;
      end
      n = $urandom_range(5, 30);
      repeat (n) begin
        k = $urandom_range(0, 99);
        if (k < 55) lookup_random();
        else if (k < 75) remove_random();
        else if (k < 96) append_random();
        else clear_list();
        left--;
      end
    end
  endtask

  task automatic run_directed();
    // empty list: lookup reports empty, remove finds nothing
    send_beat(OP_LOOKUP, '1, '1, 32'd0);
    send_beat(OP_REMOVE, 64'd0, 32'd0, '1);
    // zero-size block, then one that fills the total, then an overflowing one
    send_beat(OP_APPEND, '1, 32'd0, '1);
    send_beat(OP_APPEND, 64'd0, 32'hFFFF_FFFF, 32'd0);
    send_beat(OP_APPEND, 64'h1234, 32'd1, 32'd0);
    // index past the total, first byte (skips zero-size block), last byte
    send_beat(OP_LOOKUP, 64'd0, 32'd0, 32'hFFFF_FFFF);
    send_beat(OP_LOOKUP, '1, 32'd0, 32'd0);
    send_beat(OP_LOOKUP, 64'd0, 32'd0, 32'hFFFF_FFFE);
    // remove with size mismatch, then the real match
    send_beat(OP_REMOVE, 64'd0, 32'hFFFF_FFFE, 32'd0);
    send_beat(OP_REMOVE, 64'd0, 32'hFFFF_FFFF, 32'd0);
    // blocks held but total zero
    send_beat(OP_LOOKUP, 64'd0, 32'd0, 32'd0);
    // fill the table with offsets that wrap the address
    for (int i = 0; i < 15; i++)
      send_beat(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFF0 + 64'(i), 32'(i + 1), 32'd0);
    // table full wins over total overflow
    send_beat(OP_APPEND, 64'd5, 32'hFFFF_FFFF, 32'd0);
    send_beat(OP_LOOKUP, 64'd0, 32'd0, 32'd20);
    send_beat(OP_CLEAR, '1, '1, '1);
  endtask

  // main stimulus: reset, directed part, then random phases at several base values
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_base('1);
    run_directed();
    drain();
    write_base(64'd0);
    run_random(PHASE_ITEMS);
    drain();
    write_base({$urandom, $urandom});
    run_random(PHASE_ITEMS);
    drain();
    write_base(64'h8000_0000_0000_0000);
    run_random(PHASE_ITEMS);
    drain();
    write_base(64'd1);
    run_random(PHASE_ITEMS);
    drain();
    repeat (MAX_BLOCKS + 4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
